FILE: rtl/core/pil_pkg.sv
`default_nettype none

package pil_pkg;

    // stored word width
    localparam int unsigned WORD_W = 32;

    // request opcodes
    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_INSERT_AT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_POP_FRONT  = 3'd4,
        OP_REMOVE_AT  = 3'd5,
        OP_CONTAINS   = 3'd6
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // kind of memory walk a request needs
    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_INS  = 2'd1,
        K_REM  = 2'd2,
        K_SRCH = 2'd3
    } t_kind;

    // controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/pil_ram.sv
`default_nettype none

// Element store: one write port, one read port, registered read data.
module pil_ram #(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]            i_wr_addr,
    input  wire logic [pil_pkg::WORD_W-1:0]          i_wr_data,
    input  wire logic                                i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]            i_rd_addr,
    output logic      [pil_pkg::WORD_W-1:0]          o_rd_data
);

    logic [pil_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [pil_pkg::WORD_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/core/positional_insert_delete_list_unit.sv
`default_nettype none

// Positional insert/delete list of signed 32-bit words, up to DEPTH entries.
// Input channel (i_in_valid/o_in_ready) carries opcode, position and value;
// output channel (o_out_valid/i_out_ready) returns status, found flag and the
// element count after the request. One result per request, in order.
// With k = elements walked (insert: count-position, remove:
// count-1-position, contains: count, else 0) the walk reads k elements, and
// the result is registered once it is done and the output register is free.
// A new request is accepted once the result is registered, so only one
// request is walked at a time; a search of a full list walks DEPTH elements.
// The single read port of the element memory paces the walk: one element
// per cycle is read and, on insert or remove, written one place over.
// The result sits in an output register; a new request is taken while it
// waits, and the next result is held in the walk until that register frees.
// Reset (synchronous, active low) empties the list; memory contents are not
// cleared, as only entries below the count are ever read.
module positional_insert_delete_list_unit #(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [2:0]                         i_opcode,
    input  wire logic [$clog2(DEPTH+1)-1:0]         i_position,
    input  wire logic signed [pil_pkg::WORD_W-1:0]  i_item_value,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [1:0]                              o_status,
    output logic                                    o_found,
    output logic [$clog2(DEPTH+1)-1:0]              o_element_count
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned WW = pil_pkg::WORD_W;

    pil_pkg::t_state  r_state, n_state;
    pil_pkg::t_kind   r_kind, n_kind;
    pil_pkg::t_status r_status, n_status;
    logic [AW-1:0]    r_at, n_at;
    logic [AW-1:0]    r_addr, n_addr;
    logic [CW-1:0]    r_left, n_left;
    logic             r_pend;
    logic [AW-1:0]    r_pend_addr;
    logic [WW-1:0]    r_value;
    logic             r_found;
    logic [CW-1:0]    r_count, n_count;
    logic             r_o_valid;
    pil_pkg::t_status r_o_status;
    logic             r_o_found;
    logic [CW-1:0]    r_o_count;

    logic             accept;
    logic             done;
    logic             slot_free;
    logic             commit;
    logic             hit;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [WW-1:0]    rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [WW-1:0]    wr_data;

    // element store
    pil_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // handshake terms
    assign accept    = i_in_valid && o_in_ready;
    assign done      = (r_left == '0) && !r_pend;
    assign slot_free = !r_o_valid || i_out_ready;
    assign commit    = (r_state == pil_pkg::S_WALK) && done && slot_free;
    assign hit       = r_pend && (r_kind == pil_pkg::K_SRCH) && (rd_data == r_value);

    // request decode: checks and walk setup from the current count
    always_comb begin
        logic [CW-1:0] at_cw;
        logic          full;
        logic          empty;
        full     = (r_count == CW'(DEPTH));
        empty    = (r_count == '0);
        at_cw    = '0;
        n_kind   = pil_pkg::K_NONE;
        n_status = pil_pkg::ST_OK;
        n_left   = '0;
        n_addr   = '0;
        unique case (pil_pkg::t_op'(i_opcode))
            pil_pkg::OP_PUSH_BACK, pil_pkg::OP_PUSH_FRONT, pil_pkg::OP_INSERT_AT: begin
                if (pil_pkg::t_op'(i_opcode) == pil_pkg::OP_PUSH_BACK) begin
                    at_cw = r_count;
                end else if (pil_pkg::t_op'(i_opcode) == pil_pkg::OP_INSERT_AT) begin
                    at_cw = i_position;
                end
                if (full) begin
                    n_status = pil_pkg::ST_FULL;
                end else if (at_cw > r_count) begin
                    n_status = pil_pkg::ST_RANGE;
                end else begin
                    // shift [at, count-1] up, walking down from the top
                    n_kind = pil_pkg::K_INS;
                    n_left = r_count - at_cw;
                    n_addr = (r_count - CW'(1)) >> 0 == '0 ? '0 : AW'(r_count - CW'(1));
                end
            end
            pil_pkg::OP_POP_BACK, pil_pkg::OP_POP_FRONT, pil_pkg::OP_REMOVE_AT: begin
                if (pil_pkg::t_op'(i_opcode) == pil_pkg::OP_POP_BACK) begin
                    at_cw = r_count - CW'(1);
                end else if (pil_pkg::t_op'(i_opcode) == pil_pkg::OP_REMOVE_AT) begin
                    at_cw = i_position;
                end
                if (empty) begin
                    n_status = pil_pkg::ST_EMPTY;
                end else if (at_cw >= r_count) begin
                    n_status = pil_pkg::ST_RANGE;
                end else begin
                    // shift [at+1, count-1] down, walking up
                    n_kind = pil_pkg::K_REM;
                    n_left = r_count - CW'(1) - at_cw;
                    n_addr = AW'(at_cw) + AW'(1);
                end
            end
            pil_pkg::OP_CONTAINS: begin
                n_kind = pil_pkg::K_SRCH;
                n_left = r_count;
            end
            default: begin
            end
        endcase
        n_at = AW'(at_cw);
    end

    // count after the walk completes
    always_comb begin
        n_count = r_count;
        if ((r_kind == pil_pkg::K_INS) && (r_status == pil_pkg::ST_OK)) begin
            n_count = r_count + CW'(1);
        end else if ((r_kind == pil_pkg::K_REM) && (r_status == pil_pkg::ST_OK)) begin
            n_count = r_count - CW'(1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pil_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = pil_pkg::S_WALK;
                end
            end
            pil_pkg::S_WALK: begin
                if (commit) begin
                    n_state = pil_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pil_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs: handshake and memory port control
    always_comb begin
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_addr;
        wr_en      = 1'b0;
        wr_addr    = r_pend_addr;
        wr_data    = rd_data;
        unique case (r_state)
            pil_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
            end
            pil_pkg::S_WALK: begin
                rd_en = (r_left != '0);
                if (r_pend && (r_kind == pil_pkg::K_INS)) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pend_addr + AW'(1);
                end else if (r_pend && (r_kind == pil_pkg::K_REM)) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pend_addr - AW'(1);
                end else if (commit && (r_kind == pil_pkg::K_INS)) begin
                    // drop the new word into the opened gap
                    wr_en   = 1'b1;
                    wr_addr = r_at;
                    wr_data = r_value;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pil_pkg::S_IDLE;
            r_count   <= '0;
            r_left    <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_left <= n_left;
                r_pend <= 1'b0;
            end else if (r_state == pil_pkg::S_WALK) begin
                r_pend <= rd_en;
                if (rd_en) begin
                    r_left <= r_left - CW'(1);
                end
            end
            if (commit) begin
                r_count <= n_count;
            end
            if (commit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // walk payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= n_kind;
            r_status <= n_status;
            r_at     <= n_at;
            r_addr   <= n_addr;
            r_value  <= i_item_value;
            r_found  <= 1'b0;
        end else if (r_state == pil_pkg::S_WALK) begin
            r_pend_addr <= r_addr;
            if (rd_en) begin
                r_addr <= (r_kind == pil_pkg::K_INS) ? r_addr - AW'(1) : r_addr + AW'(1);
            end
            if (hit) begin
                r_found <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_count  <= n_count;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_status        = r_o_status;
    assign o_found         = r_o_found;
    assign o_element_count = r_o_count;

    // the list never grows past the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count beyond capacity");

    // memory is never written between requests
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pil_pkg::S_IDLE) |-> !wr_en)
        else $error("memory write while idle");

    // a successful insert adds exactly one element
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (r_kind == pil_pkg::K_INS) && (r_status == pil_pkg::ST_OK))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not advance count");

    // a successful removal takes exactly one element
    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (r_kind == pil_pkg::K_REM) && (r_status == pil_pkg::ST_OK))
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("remove did not reduce count");

    // found is only reported by a search
    a_found_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_found) |-> (r_kind == pil_pkg::K_SRCH))
        else $error("found flag outside a search");

endmodule

`default_nettype wire

FILE: tb/sv/positional_insert_delete_list_unit_test.sv
module positional_insert_delete_list_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIST_DEPTH   = 256;
    localparam int unsigned CW           = $clog2(LIST_DEPTH + 1);
    localparam int unsigned WW           = pil_pkg::WORD_W;
    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam int unsigned POOL_SIZE    = 8;
    // opcode with no operation behind it
    localparam logic [2:0]  OP_UNUSED    = 3'd7;
    // watchdog limit in ns, well above the slowest legal run
    localparam longint unsigned WATCHDOG_NS = 64'd25_000_000;

    typedef struct packed {
        pil_pkg::t_status status;
        logic             found;
        logic [CW-1:0]    count;
    } t_list_result;

    typedef struct packed {
        logic [2:0]        op;
        logic [CW-1:0]     pos;
        logic [WW-1:0]     word;
        bit                typed;
        t_list_result      want;
    } t_directed_row;

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [2:0]               i_opcode = '0;
    logic [CW-1:0]            i_position = '0;
    logic signed [WW-1:0]     i_item_value = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [1:0]               o_status;
    logic                     o_found;
    logic [CW-1:0]            o_element_count;

    // shadow of the list contents and the results still owed by the block
    logic signed [WW-1:0]     shadow_list [$];
    t_list_result             expected_results [$];

    int unsigned send_idle_pct = 0;
    int unsigned out_stall_pct = 0;
    int unsigned requests_sent = 0;
    int unsigned random_sent = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count = 0;
    int unsigned search_hits = 0;
    int unsigned status_seen [4] = '{0, 0, 0, 0};

    int unsigned phase_send_idle [4] = '{0, 55, 0, 14};
    int unsigned phase_out_stall [4] = '{0, 0, 55, 14};

    logic signed [WW-1:0] value_pool [POOL_SIZE] = '{
        32'sh0000_0000, 32'shFFFF_FFFF, 32'sh0000_0001, 32'sh8000_0000,
        32'sh7FFF_FFFF, 32'sh5A5A_5A5A, 32'shA5A5_A5A5, 32'sh0000_0064
    };

    // directed opening: empty-list errors, extremes, range errors, searches
    t_directed_row directed_rows [25] = '{
        '{pil_pkg::OP_POP_BACK,   0,   32'sh0,         1'b1, '{pil_pkg::ST_EMPTY, 1'b0, 0}},
        '{pil_pkg::OP_POP_FRONT,  0,   32'sh0,         1'b1, '{pil_pkg::ST_EMPTY, 1'b0, 0}},
        '{pil_pkg::OP_REMOVE_AT,  0,   32'sh0,         1'b1, '{pil_pkg::ST_EMPTY, 1'b0, 0}},
        '{pil_pkg::OP_REMOVE_AT,  511, 32'shFFFF_FFFF, 1'b1, '{pil_pkg::ST_EMPTY, 1'b0, 0}},
        '{pil_pkg::OP_CONTAINS,   0,   32'sh0,         1'b1, '{pil_pkg::ST_OK,    1'b0, 0}},
        '{OP_UNUSED,              511, 32'shFFFF_FFFF, 1'b1, '{pil_pkg::ST_OK,    1'b0, 0}},
        '{pil_pkg::OP_INSERT_AT,  1,   32'sh1234_5678, 1'b1, '{pil_pkg::ST_RANGE, 1'b0, 0}},
        '{pil_pkg::OP_PUSH_BACK,  0,   32'sh7FFF_FFFF, 1'b1, '{pil_pkg::ST_OK,    1'b0, 1}},
        '{pil_pkg::OP_PUSH_FRONT, 511, 32'sh8000_0000, 1'b1, '{pil_pkg::ST_OK,    1'b0, 2}},
        '{pil_pkg::OP_INSERT_AT,  1,   32'sh0,         1'b0, '{pil_pkg::ST_OK,    1'b0, 0}},
        '{pil_pkg::OP_INSERT_AT,  3,   32'shFFFF_FFFF, 1'b0, '{pil_pkg::ST_OK,    1'b0, 0}},
        '{pil_pkg::OP_INSERT_AT,  5,   32'sh0000_0001, 1'b1, '{pil_pkg::ST_RANGE, 1'b0, 4}},
        '{pil_pkg::OP_INSERT_AT,  511, 32'sh0000_0001, 1'b1, '{pil_pkg::ST_RANGE, 1'b0, 4}},
        '{pil_pkg::OP_CONTAINS,   0,   32'sh8000_0000, 1'b1, '{pil_pkg::ST_OK,    1'b1, 4}},
        '{pil_pkg::OP_CONTAINS,   0,   32'sh7FFF_FFFF, 1'b1, '{pil_pkg::ST_OK,    1'b1, 4}},
        '{pil_pkg::OP_CONTAINS,   0,   32'sh0000_0005, 1'b1, '{pil_pkg::ST_OK,    1'b0, 4}},
        '{pil_pkg::OP_REMOVE_AT,  4,   32'sh0,         1'b1, '{pil_pkg::ST_RANGE, 1'b0, 4}},
        '{pil_pkg::OP_REMOVE_AT,  1,   32'sh0,         1'b0, '{pil_pkg::ST_OK,    1'b0, 0}},
        '{pil_pkg::OP_CONTAINS,   256, 32'sh0,         1'b0, '{pil_pkg::ST_OK,    1'b0, 0}},
        '{OP_UNUSED,              0,   32'sh0,         1'b1, '{pil_pkg::ST_OK,    1'b0, 3}},
        '{pil_pkg::OP_POP_BACK,   0,   32'sh0,         1'b1, '{pil_pkg::ST_OK,    1'b0, 2}},
        '{pil_pkg::OP_POP_FRONT,  0,   32'sh0,         1'b1, '{pil_pkg::ST_OK,    1'b0, 1}},
        '{pil_pkg::OP_REMOVE_AT,  0,   32'sh0,         1'b1, '{pil_pkg::ST_OK,    1'b0, 0}},
        '{pil_pkg::OP_PUSH_BACK,  256, 32'sh5555_5555, 1'b1, '{pil_pkg::ST_OK,    1'b0, 1}},
        '{pil_pkg::OP_POP_FRONT,  0,   32'sh0,         1'b1, '{pil_pkg::ST_OK,    1'b0, 0}}
    };

    positional_insert_delete_list_unit #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_position      (i_position),
        .i_item_value    (i_item_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_found         (o_found),
        .o_element_count (o_element_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(WATCHDOG_NS);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void record_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endfunction

    // list edits; a full list is refused before the position is looked at
    function automatic pil_pkg::t_status list_insert(input int at,
                                                     input logic signed [WW-1:0] word);
        if (shadow_list.size() >= LIST_DEPTH) begin
            return pil_pkg::ST_FULL;
        end
        if (at > shadow_list.size()) begin
            return pil_pkg::ST_RANGE;
        end
        shadow_list.insert(at, word);
        return pil_pkg::ST_OK;
    endfunction

    // an empty list is refused before the position is looked at
    function automatic pil_pkg::t_status list_remove(input int at);
        if (shadow_list.size() == 0) begin
            return pil_pkg::ST_EMPTY;
        end
        if (at >= shadow_list.size()) begin
            return pil_pkg::ST_RANGE;
        end
        shadow_list.delete(at);
        return pil_pkg::ST_OK;
    endfunction

    // one request against the shadow list; returns the result it must produce
    function automatic t_list_result apply_list_request(
        input logic [2:0]           op,
        input logic [CW-1:0]        pos,
        input logic signed [WW-1:0] word
    );
        t_list_result res;
        res = '0;
        case (op)
            pil_pkg::OP_PUSH_BACK:  res.status = list_insert(shadow_list.size(), word);
            pil_pkg::OP_PUSH_FRONT: res.status = list_insert(0, word);
            pil_pkg::OP_INSERT_AT:  res.status = list_insert(int'(pos), word);
            pil_pkg::OP_POP_BACK:   res.status = list_remove(shadow_list.size() - 1);
            pil_pkg::OP_POP_FRONT:  res.status = list_remove(0);
            pil_pkg::OP_REMOVE_AT:  res.status = list_remove(int'(pos));
            pil_pkg::OP_CONTAINS: begin
                foreach (shadow_list[i]) begin
                    if (shadow_list[i] == word) begin
                        res.found = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.count = CW'(shadow_list.size());
        return res;
    endfunction

    // drive one request transaction and log what it must return
    task automatic issue_request(
        input logic [2:0]           op,
        input logic [CW-1:0]        pos,
        input logic signed [WW-1:0] word,
        input bit                   typed,
        input t_list_result         want
    );
        t_list_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_position   <= pos;
        i_item_value <= word;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predicted = apply_list_request(op, pos, word);
        expected_results.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    task automatic send_random(
        input logic [2:0]           op,
        input logic [CW-1:0]        pos,
        input logic signed [WW-1:0] word
    );
        issue_request(op, pos, word, 1'b0, '0);
        if (op != OP_UNUSED) begin
            random_sent++;
        end
    endtask

    // hold the sender off until the block has answered everything
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    function automatic logic signed [WW-1:0] pick_value();
        if ($urandom_range(1) == 1) begin
            return value_pool[$urandom_range(POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    // half the time a value that is stored, so searches hit
    function automatic logic signed [WW-1:0] pick_search_value();
        if (shadow_list.size() > 0 && $urandom_range(1) == 1) begin
            return shadow_list[$urandom_range(shadow_list.size() - 1)];
        end
        return pick_value();
    endfunction

    // legal index most of the time, ends favored, any 9-bit value otherwise
    function automatic logic [CW-1:0] pick_position(input bit for_insert);
        int          limit;
        int unsigned roll;
        limit = for_insert ? shadow_list.size() : shadow_list.size() - 1;
        roll = $urandom_range(7);
        if (limit < 0 || roll < 2) begin
            return CW'($urandom_range((1 << CW) - 1));
        end
        if (roll == 2) begin
            return '0;
        end
        if (roll == 3) begin
            return CW'(limit);
        end
        return CW'($urandom_range(limit));
    endfunction

    // fill to capacity, then probe the full list
    task automatic climb_to_full();
        int unsigned roll;
        while (shadow_list.size() < LIST_DEPTH && random_sent < RANDOM_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                send_random(pil_pkg::OP_PUSH_BACK, CW'($urandom), pick_value());
            end else if (roll < 85) begin
                send_random(pil_pkg::OP_PUSH_FRONT, CW'($urandom), pick_value());
            end else begin
                send_random(pil_pkg::OP_INSERT_AT, pick_position(1'b1), pick_value());
            end
        end
        send_random(pil_pkg::OP_PUSH_BACK, CW'($urandom), pick_value());
        send_random(pil_pkg::OP_PUSH_FRONT, CW'($urandom), pick_value());
        send_random(pil_pkg::OP_INSERT_AT, CW'($urandom), pick_value());
        send_random(pil_pkg::OP_INSERT_AT, CW'(LIST_DEPTH), pick_value());
        send_random(pil_pkg::OP_CONTAINS, CW'($urandom), pick_search_value());
        send_random(pil_pkg::OP_CONTAINS, CW'($urandom), pick_value());
        send_random(pil_pkg::OP_REMOVE_AT, pick_position(1'b0), pick_value());
    endtask

    // empty the list, then probe the empty list
    task automatic drain_to_empty();
        int unsigned roll;
        while (shadow_list.size() > 0 && random_sent < RANDOM_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < 50) begin
                send_random(pil_pkg::OP_POP_BACK, CW'($urandom), pick_value());
            end else if (roll < 75) begin
                send_random(pil_pkg::OP_POP_FRONT, CW'($urandom), pick_value());
            end else begin
                send_random(pil_pkg::OP_REMOVE_AT, pick_position(1'b0), pick_value());
            end
        end
        send_random(pil_pkg::OP_POP_BACK, CW'($urandom), pick_value());
        send_random(pil_pkg::OP_POP_FRONT, CW'($urandom), pick_value());
        send_random(pil_pkg::OP_REMOVE_AT, CW'($urandom), pick_value());
        send_random(pil_pkg::OP_CONTAINS, CW'($urandom), pick_value());
        send_random(pil_pkg::OP_INSERT_AT, pick_position(1'b1), pick_value());
    endtask

    // free mix of all operations, a little unused-opcode noise included
    task automatic random_mix(input int unsigned length);
        int unsigned roll;
        repeat (length) begin
            roll = $urandom_range(99);
            if (roll < 14) begin
                send_random(pil_pkg::OP_PUSH_BACK, CW'($urandom), pick_value());
            end else if (roll < 26) begin
                send_random(pil_pkg::OP_PUSH_FRONT, CW'($urandom), pick_value());
            end else if (roll < 42) begin
                send_random(pil_pkg::OP_INSERT_AT, pick_position(1'b1), pick_value());
            end else if (roll < 52) begin
                send_random(pil_pkg::OP_POP_BACK, CW'($urandom), pick_value());
            end else if (roll < 60) begin
                send_random(pil_pkg::OP_POP_FRONT, CW'($urandom), pick_value());
            end else if (roll < 74) begin
                send_random(pil_pkg::OP_REMOVE_AT, pick_position(1'b0), pick_value());
            end else if (roll < 96) begin
                send_random(pil_pkg::OP_CONTAINS, CW'($urandom), pick_search_value());
            end else begin
                send_random(OP_UNUSED, CW'($urandom), pick_value());
            end
        end
    endtask

    // result side: check each transaction, then pick the next ready
    initial begin
        t_list_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    record_failure($sformatf(
                        "unexpected result: status %0d found %0d count %0d",
                        o_status, o_found, o_element_count));
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    status_seen[want.status]++;
                    if (want.found) begin
                        search_hits++;
                    end
                    if (o_status !== want.status || o_found !== want.found ||
                        o_element_count !== want.count) begin
                        record_failure($sformatf(
                            "result %0d: expected status %0d found %0d count %0d, got %0d %0d %0d",
                            results_checked, want.status, want.found, want.count,
                            o_status, o_found, o_element_count));
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // request side
    initial begin
        int unsigned phase;
        int unsigned next_phase;
        int unsigned episode;
        int unsigned roll;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            issue_request(directed_rows[r].op, directed_rows[r].pos, directed_rows[r].word,
                          directed_rows[r].typed, directed_rows[r].want);
        end

        // random episodes; first a full climb and a full drain
        phase = 0;
        episode = 0;
        while (random_sent < RANDOM_ITEMS) begin
            next_phase = (random_sent * 4) / RANDOM_ITEMS;
            if (next_phase > 3) begin
                next_phase = 3;
            end
            if (next_phase != phase) begin
                phase = next_phase;
                wait_all_results();
                send_idle_pct = phase_send_idle[phase];
                out_stall_pct = phase_out_stall[phase];
            end
            roll = $urandom_range(99);
            if (episode == 0 || (episode > 1 && roll >= 85)) begin
                climb_to_full();
            end else if (episode == 1 || roll >= 70) begin
                drain_to_empty();
            end else begin
                random_mix($urandom_range(20, 40));
            end
            episode++;
        end

        // let the block finish; late or extra results still get checked
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LIST_DEPTH + 8) @(posedge i_clk);

        $display("Ran %0d requests, %0d results checked, %0d mismatches, under four idle mixes",
                 requests_sent, results_checked, mismatch_count);
        $display("Answers: ok %0d, empty %0d, full %0d, bad index %0d; search hits %0d",
                 status_seen[pil_pkg::ST_OK], status_seen[pil_pkg::ST_EMPTY],
                 status_seen[pil_pkg::ST_FULL], status_seen[pil_pkg::ST_RANGE], search_hits);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
